// ----- rtl/core/wclf_pkg.sv -----
// Package for the word clock LED frame: item types, LED map constants and word masks.
`default_nettype none
package wclf_pkg;

  localparam int LedCount  = 114;
  localparam int LowWidth  = 64;
  localparam int HighWidth = LedCount - LowWidth;

  typedef logic [LedCount-1:0] frame_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
  } in_item_t;

  typedef struct packed {
    logic [LowWidth-1:0]  leds_low;
    logic [HighWidth-1:0] leds_high;
    logic                 time_invalid;
  } out_item_t;

  localparam logic [4:0] HourLast    = 5'd23;
  localparam logic [5:0] MinuteLast  = 6'd59;
  localparam logic [5:0] HalfAhead   = 6'd24;
  localparam logic [5:0] EinMinLast  = 6'd4;
  localparam int         DotFirst    = 110;
  localparam int         ErrorLed    = 2;
  localparam int         EinsSLed    = 62;

  // Mask with LEDs first up to but not including last lit.
  function automatic frame_t span_mask(input int first, input int last);
    frame_t mask;
    for (int i = 0; i < LedCount; i++) begin
      mask[i] = (i >= first) && (i < last);
    end
    return mask;
  endfunction

  localparam frame_t MaskEsIst   = span_mask(0, 2) | span_mask(3, 6);
  localparam frame_t MaskError   = span_mask(ErrorLed, ErrorLed + 1);
  localparam frame_t MaskUhr     = span_mask(99, 102);
  localparam frame_t MaskFuenf   = span_mask(7, 11);
  localparam frame_t MaskZehn    = span_mask(18, 22);
  localparam frame_t MaskViertel = span_mask(26, 33);
  localparam frame_t MaskZwanzig = span_mask(11, 18);
  localparam frame_t MaskNach    = span_mask(33, 37);
  localparam frame_t MaskVor     = span_mask(41, 44);
  localparam frame_t MaskHalb    = span_mask(44, 48);

  localparam frame_t MaskHEin    = span_mask(63, 66);
  localparam frame_t MaskHS      = span_mask(EinsSLed, EinsSLed + 1);
  localparam frame_t MaskHZwei   = span_mask(55, 59);
  localparam frame_t MaskHDrei   = span_mask(66, 70);
  localparam frame_t MaskHVier   = span_mask(73, 77);
  localparam frame_t MaskHFuenf  = span_mask(51, 55);
  localparam frame_t MaskHSechs  = span_mask(83, 88);
  localparam frame_t MaskHSieben = span_mask(88, 94);
  localparam frame_t MaskHAcht   = span_mask(77, 81);
  localparam frame_t MaskHNeun   = span_mask(103, 107);
  localparam frame_t MaskHZehn   = span_mask(106, 110);
  localparam frame_t MaskHElf    = span_mask(49, 52);
  localparam frame_t MaskHZwoelf = span_mask(94, 99);

endpackage
`default_nettype wire

// ----- rtl/core/word_clock_led_frame_core.sv -----
// Top level of the word clock LED frame: maps one time item to a 114-LED frame.
//
//   channel  | ports                      | handshake
//   ---------+----------------------------+----------------------------------
//   input    | start, busy, in_item       | accepted when start && !busy
//   result   | out_valid, out_item        | one-cycle strobe, cannot be held
//
// An item is accepted in every cycle; busy is never raised.
// Each accepted item passes through the input register and then the result
// register, with the word decode between them.
// Reset (synchronous, rst_n low) clears both valid flags; nothing else is reset.
// The receiver cannot stall, so there is no backpressure path.
`default_nettype none
module word_clock_led_frame_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire wclf_pkg::in_item_t   in_item,
  output logic                      out_valid,
  output wclf_pkg::out_item_t       out_item
);

  logic                in_valid_r;
  logic [4:0]          hour_r;
  logic [5:0]          minute_r;
  logic                out_valid_r;
  wclf_pkg::out_item_t out_item_r;
  wclf_pkg::out_item_t out_item_nxt;

  logic                bad;
  logic [9:0]          min_prod;
  logic [3:0]          min_quot;
  logic [5:0]          min_rem_full;
  logic [2:0]          min_rem;
  logic [4:0]          hour_diff;
  logic [3:0]          hour_mod;
  logic [3:0]          hour_12;
  logic [3:0]          hour_show;
  wclf_pkg::frame_t    dot_mask;
  wclf_pkg::frame_t    min_mask;
  wclf_pkg::frame_t    hour_mask;
  wclf_pkg::frame_t    frame;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      hour_r   <= in_item.hour;
      minute_r <= in_item.minute;
    end
    if (in_valid_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  // minute / 5 as (minute * 13) >> 6, exact for all 6-bit minutes.
  assign min_prod     = {1'b0, minute_r, 3'b000} + {2'b00, minute_r, 2'b00}
                      + {4'b0000, minute_r};
  assign min_quot     = min_prod[9:6];
  assign min_rem_full = minute_r - ({min_quot, 2'b00} + {2'b00, min_quot});
  assign min_rem      = min_rem_full[2:0];

  assign bad = (hour_r > wclf_pkg::HourLast) || (minute_r > wclf_pkg::MinuteLast);

  assign hour_diff = hour_r - 5'd12;
  assign hour_mod  = (hour_r >= 5'd12) ? hour_diff[3:0] : hour_r[3:0];
  assign hour_12   = (hour_mod == 4'd0) ? 4'd12 : hour_mod;

  always_comb begin
    if (minute_r > wclf_pkg::HalfAhead) begin
      hour_show = (hour_12 == 4'd12) ? 4'd1 : hour_12 + 4'd1;
    end else begin
      hour_show = hour_12;
    end
  end

  always_comb begin
    dot_mask = '0;
    case (min_rem)
      3'd1:    dot_mask = wclf_pkg::span_mask(wclf_pkg::DotFirst, wclf_pkg::DotFirst + 1);
      3'd2:    dot_mask = wclf_pkg::span_mask(wclf_pkg::DotFirst, wclf_pkg::DotFirst + 2);
      3'd3:    dot_mask = wclf_pkg::span_mask(wclf_pkg::DotFirst, wclf_pkg::DotFirst + 3);
      3'd4:    dot_mask = wclf_pkg::span_mask(wclf_pkg::DotFirst, wclf_pkg::DotFirst + 4);
      default: dot_mask = '0;
    endcase
  end

  always_comb begin
    case (min_quot)
      4'd0:    min_mask = wclf_pkg::MaskUhr;
      4'd1:    min_mask = wclf_pkg::MaskFuenf | wclf_pkg::MaskNach;
      4'd2:    min_mask = wclf_pkg::MaskZehn | wclf_pkg::MaskNach;
      4'd3:    min_mask = wclf_pkg::MaskViertel | wclf_pkg::MaskNach;
      4'd4:    min_mask = wclf_pkg::MaskZwanzig | wclf_pkg::MaskNach;
      4'd5:    min_mask = wclf_pkg::MaskFuenf | wclf_pkg::MaskVor | wclf_pkg::MaskHalb;
      4'd6:    min_mask = wclf_pkg::MaskHalb;
      4'd7:    min_mask = wclf_pkg::MaskFuenf | wclf_pkg::MaskNach | wclf_pkg::MaskHalb;
      4'd8:    min_mask = wclf_pkg::MaskZwanzig | wclf_pkg::MaskVor;
      4'd9:    min_mask = wclf_pkg::MaskViertel | wclf_pkg::MaskVor;
      4'd10:   min_mask = wclf_pkg::MaskZehn | wclf_pkg::MaskVor;
      default: min_mask = wclf_pkg::MaskFuenf | wclf_pkg::MaskVor;
    endcase
  end

  always_comb begin
    case (hour_show)
      4'd1: begin
        // EIN for minutes 0 to 4 (with UHR), EINS at any later minute.
        hour_mask = wclf_pkg::MaskHEin;
        if (minute_r > wclf_pkg::EinMinLast) begin
          hour_mask = wclf_pkg::MaskHEin | wclf_pkg::MaskHS;
        end
      end
      4'd2:    hour_mask = wclf_pkg::MaskHZwei;
      4'd3:    hour_mask = wclf_pkg::MaskHDrei;
      4'd4:    hour_mask = wclf_pkg::MaskHVier;
      4'd5:    hour_mask = wclf_pkg::MaskHFuenf;
      4'd6:    hour_mask = wclf_pkg::MaskHSechs;
      4'd7:    hour_mask = wclf_pkg::MaskHSieben;
      4'd8:    hour_mask = wclf_pkg::MaskHAcht;
      4'd9:    hour_mask = wclf_pkg::MaskHNeun;
      4'd10:   hour_mask = wclf_pkg::MaskHZehn;
      4'd11:   hour_mask = wclf_pkg::MaskHElf;
      default: hour_mask = wclf_pkg::MaskHZwoelf;
    endcase
  end

  always_comb begin
    if (bad) begin
      frame = wclf_pkg::MaskEsIst | wclf_pkg::MaskError;
    end else begin
      frame = wclf_pkg::MaskEsIst | dot_mask | min_mask | hour_mask;
    end
    out_item_nxt.leds_low     = frame[wclf_pkg::LowWidth-1:0];
    out_item_nxt.leds_high    = frame[wclf_pkg::LedCount-1:wclf_pkg::LowWidth];
    out_item_nxt.time_invalid = bad;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

// ----- rtl/core/wclf_checker.sv -----
// Port-level checker for the word clock LED frame core, with its bind statement.
`default_nettype none
module wclf_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_valid,
  input wire wclf_pkg::out_item_t out_item
);

  // Every accepted item yields its result once it has passed both registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted item produced no result two cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result strobe without an accepted item");

  a_es_ist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.leds_low[1:0] == 2'b11 && out_item.leds_low[5:3] == 3'b111))
    else $error("ES IST not lit");

  a_error_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.leds_low[2] == out_item.time_invalid))
    else $error("error LED does not match the invalid flag");

  // An invalid time shows no hour words, no UHR and no dots; this checks the upper LEDs only.
  a_invalid_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.time_invalid) |-> (out_item.leds_high == '0))
    else $error("invalid time lights upper LEDs");

endmodule

bind word_clock_led_frame_core wclf_checker u_wclf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
`default_nettype wire
